@@ hw/rtl/gefs_pkg.sv @@
// Package for the grayscale edge filter stream.
// Holds pixel and sum types, register indexes and mode codes.
// Depends on nothing; the top level imports it.
package gefs_pkg;

  localparam int PIX_W       = 8;
  localparam int SUM_W       = 14;
  localparam int WIDTH_W     = 11;
  localparam int HEIGHT_W    = 16;
  localparam int MODE_W      = 2;
  localparam int ITEMS_W     = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int STORED_ROWS = 4;
  localparam int WIN         = STORED_ROWS + 1;
  localparam int LANES_W     = STORED_ROWS * PIX_W;
  localparam int WIDTH_CAP   = 1024;

  localparam logic [ITEMS_W-1:0]  ITEMS_MAX = '1;
  localparam logic [HEIGHT_W-1:0] ROW_MAX   = '1;
  localparam logic [PIX_W-1:0]    PIX_MAX   = '1;

  typedef logic [PIX_W-1:0]        pix_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_PREWITT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SOBEL   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOG     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_COPY    = 2'd3;

  typedef struct packed {
    logic emit;
    logic pass;
    logic last;
  } item_ctl_t;

endpackage

@@ hw/rtl/grayscale_edge_filter_stream.sv @@
// Channel   Dir  Signals                                  Request
// s_axis    in   tvalid tready tdata[7:0] tuser           one raster pixel or flush tick
// m_axis    out  tvalid tready tdata[7:0] tlast           one filtered pixel
// cfg       in   cfg_we cfg_index[1:0] cfg_wdata[15:0]    one register write
//
// Top level of the grayscale edge filter stream: line store, 5x5 window and adder stages.
// Depends on gefs_pkg.
//
// One request is taken every cycle while m_axis is not stalled; its result is registered in
// stage 1, stage 2 and the output register before it is presented on m_axis.
// The rate is set by the line store, read at one column and written at another each cycle.
// The first 2*width+2 requests of a frame give no result.
// Reset clears counters and the window; the line store is not cleared.
// Output stalls fill the two inner stages before the input side stops.
module grayscale_edge_filter_stream
  import gefs_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // pixel_in
  input  logic                  s_axis_tuser,   // kind
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // pixel_out
  output logic                  m_axis_tlast,   // frame_last
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int LINE_DEPTH = (MAX_WIDTH < WIDTH_CAP) ? MAX_WIDTH : WIDTH_CAP;
  localparam int COL_W      = $clog2(LINE_DEPTH);
  localparam logic [WIDTH_W-1:0] WIDTH_LIM = WIDTH_W'(LINE_DEPTH);

  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [MODE_W-1:0]   edge_mode;

  logic [WIDTH_W-1:0]  eff_w;
  logic [HEIGHT_W-1:0] eff_h;

  logic [COL_W-1:0]    in_column, in_column_next;
  logic [HEIGHT_W-1:0] in_row, in_row_next;
  logic [COL_W-1:0]    out_column, out_column_next;
  logic [HEIGHT_W-1:0] out_row, out_row_next;
  logic [ITEMS_W-1:0]  items_seen, items_seen_next;

  logic [COL_W-1:0]    col_c;
  logic [COL_W-1:0]    ocol_c;
  pix_t                newpix;
  item_ctl_t           acc_ctl;
  logic                in_acc;

  logic [LANES_W-1:0]  line_mem [LINE_DEPTH];
  logic [LANES_W-1:0]  line_rd;

  logic                s1_valid;
  logic [COL_W-1:0]    s1_col;
  pix_t                s1_pix;
  item_ctl_t           s1_ctl;
  logic                s1_go, s1_room;

  pix_t                win [WIN][WIN];
  sum_t                wx  [WIN][WIN];
  sum_t                g_c [4];

  logic                s2_valid;
  item_ctl_t           s2_ctl;
  sum_t                s2_g [4];
  pix_t                s2_cen;
  logic                s2_go, s2_room;

  sum_t                total;
  pix_t                res_pix;
  logic                out_free;

  // Effective frame size.
  always_comb begin
    if (image_width < WIDTH_W'(3)) begin
      eff_w = WIDTH_W'(3);
    end else if (image_width > WIDTH_LIM) begin
      eff_w = WIDTH_LIM;
    end else begin
      eff_w = image_width;
    end
    eff_h = (image_height < HEIGHT_W'(3)) ? HEIGHT_W'(3) : image_height;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_W'(640);
      image_height <= HEIGHT_W'(480);
      edge_mode    <= MODE_SOBEL;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  image_width  <= cfg_wdata[WIDTH_W-1:0];
        CFG_HEIGHT: image_height <= cfg_wdata[HEIGHT_W-1:0];
        CFG_MODE:   edge_mode    <= cfg_wdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and stage flow.
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s2_go         = s2_valid && (!s2_ctl.emit || out_free);
  assign s2_room       = !s2_valid || s2_go;
  assign s1_go         = s1_valid && s2_room;
  assign s1_room       = !s1_valid || s1_go;
  assign s_axis_tready = s1_room;
  assign in_acc        = s_axis_tvalid && s1_room;

  // Position counters and per-request decisions.
  always_comb begin
    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    items_seen_next = items_seen;

    col_c  = (WIDTH_W'(in_column) >= eff_w) ? '0 : in_column;
    ocol_c = (WIDTH_W'(out_column) >= eff_w) ? '0 : out_column;
    newpix = (in_row < eff_h && !s_axis_tuser) ? s_axis_tdata : '0;

    acc_ctl.emit = (ITEMS_W'(items_seen) >= ITEMS_W'({eff_w, 1'b0} + (WIDTH_W + 1)'(2)));
    acc_ctl.last = (out_row >= eff_h - HEIGHT_W'(1)) && (WIDTH_W'(ocol_c) >= eff_w - WIDTH_W'(1));
    acc_ctl.pass = (out_row == '0) || (out_row >= eff_h - HEIGHT_W'(1)) || (ocol_c == '0)
                || (WIDTH_W'(ocol_c) >= eff_w - WIDTH_W'(1)) || (edge_mode == MODE_COPY);
    if (edge_mode == MODE_LOG && ((out_row == HEIGHT_W'(1)) || (out_row >= eff_h - HEIGHT_W'(2))
        || (ocol_c == COL_W'(1)) || (WIDTH_W'(ocol_c) >= eff_w - WIDTH_W'(2)))) begin
      acc_ctl.pass = 1'b1;
    end

    if (in_acc) begin
      if (WIDTH_W'(col_c) + WIDTH_W'(1) >= eff_w) begin
        in_column_next = '0;
        if (in_row < eff_h) begin
          in_row_next = in_row + HEIGHT_W'(1);
        end
      end else begin
        in_column_next = col_c + COL_W'(1);
      end

      if (acc_ctl.emit && acc_ctl.last) begin
        in_column_next  = '0;
        in_row_next     = '0;
        out_column_next = '0;
        out_row_next    = '0;
        items_seen_next = '0;
      end else begin
        if (acc_ctl.emit) begin
          if (WIDTH_W'(ocol_c) + WIDTH_W'(1) >= eff_w) begin
            out_column_next = '0;
            if (out_row != ROW_MAX) begin
              out_row_next = out_row + HEIGHT_W'(1);
            end
          end else begin
            out_column_next = ocol_c + COL_W'(1);
          end
        end
        if (items_seen != ITEMS_MAX) begin
          items_seen_next = items_seen + ITEMS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      items_seen <= '0;
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
      items_seen <= items_seen_next;
    end
  end

  // Line store: four rows per column entry, oldest row in the lowest lane.
  always_ff @(posedge clk) begin
    if (s1_go) begin
      line_mem[s1_col] <= {s1_pix, line_rd[LANES_W-1:PIX_W]};
    end
    if (in_acc) begin
      line_rd <= line_mem[col_c];
    end
  end

  // Stage 1: line store data arrives, window shifts, partial sums form.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_room) begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col <= col_c;
      s1_pix <= newpix;
      s1_ctl <= acc_ctl;
    end
  end

  always_comb begin
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < WIN - 1; c++) begin
        wx[r][c] = sum_t'(win[r][c+1]);
      end
    end
    for (int r = 0; r < STORED_ROWS; r++) begin
      wx[r][WIN-1] = sum_t'(line_rd[r*PIX_W +: PIX_W]);
    end
    wx[WIN-1][WIN-1] = sum_t'(s1_pix);
  end

  always_comb begin
    if (edge_mode == MODE_LOG) begin
      g_c[0] = (wx[2][2] <<< 4) - wx[0][2] - wx[4][2] - wx[2][0];
      g_c[1] = -wx[2][4] - wx[1][1] - wx[1][3] - wx[3][1];
      g_c[2] = -wx[3][3] - ((wx[1][2] + wx[3][2]) <<< 1);
      g_c[3] = -((wx[2][1] + wx[2][3]) <<< 1);
    end else if (edge_mode == MODE_SOBEL) begin
      g_c[0] = (wx[3][3] - wx[1][1]) <<< 1;
      g_c[1] = (wx[2][3] + wx[3][2]) <<< 1;
      g_c[2] = -((wx[2][1] + wx[1][2]) <<< 1);
      g_c[3] = '0;
    end else begin
      g_c[0] = (wx[3][3] - wx[1][1]) <<< 1;
      g_c[1] = wx[2][3] + wx[3][2];
      g_c[2] = -(wx[2][1] + wx[1][2]);
      g_c[3] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < WIN; r++) begin
        for (int c = 0; c < WIN; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (s1_go) begin
      for (int r = 0; r < WIN; r++) begin
        for (int c = 0; c < WIN - 1; c++) begin
          win[r][c] <= win[r][c+1];
        end
      end
      for (int r = 0; r < STORED_ROWS; r++) begin
        win[r][WIN-1] <= line_rd[r*PIX_W +: PIX_W];
      end
      win[WIN-1][WIN-1] <= s1_pix;
    end
  end

  // Stage 2: final sum, saturation and border select.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_room) begin
      s2_valid <= s1_go;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_ctl <= s1_ctl;
      s2_cen <= win[2][3];
      for (int i = 0; i < 4; i++) begin
        s2_g[i] <= g_c[i];
      end
    end
  end

  always_comb begin
    total = s2_g[0] + s2_g[1] + s2_g[2] + s2_g[3];
    if (s2_ctl.pass) begin
      res_pix = s2_cen;
    end else if (total < sum_t'(0)) begin
      res_pix = '0;
    end else if (total > sum_t'(PIX_MAX)) begin
      res_pix = PIX_MAX;
    end else begin
      res_pix = total[PIX_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= s2_go && s2_ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_go && s2_ctl.emit) begin
      m_axis_tdata <= res_pix;
      m_axis_tlast <= s2_ctl.last;
    end
  end

`ifndef SYNTHESIS
  a_no_col_clash: assert property (@(posedge clk) disable iff (rst)
    (s1_go && in_acc) |-> (s1_col != col_c))
    else $error("line store write and read hit the same column");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (in_acc && acc_ctl.emit && acc_ctl.last) |=> (items_seen == '0 && out_row == '0))
    else $error("counters not cleared after the last pixel of a frame");

  a_s2_held: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_ctl.emit && !out_free) |=> (s2_valid && $stable(s2_cen)))
    else $error("pending result in stage 2 lost during output stall");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for grayscale_edge_filter_stream.
// It predicts every filtered pixel from the raster requests it sends and checks
// the results in order. It depends on gefs_pkg and the top level of the filter.
`timescale 1ns / 1ps

module tb;
  import gefs_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int TB_MAX_W   = 1024;

  typedef struct packed {
    logic kind;
    pix_t value;
    logic hold;
  } pix_req_t;

  typedef struct packed {
    pix_t value;
    logic last;
  } filt_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  grayscale_edge_filter_stream #(.MAX_WIDTH(TB_MAX_W)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  pix_req_t raster_q[$];
  filt_t    filtered_q[$];
  filt_t    want;

  logic [WIDTH_W-1:0]  w_reg = 11'd640;
  logic [HEIGHT_W-1:0] h_reg = 16'd480;
  logic [MODE_W-1:0]   mode_reg = MODE_SOBEL;

  pix_t line_mem [STORED_ROWS][TB_MAX_W];
  pix_t win [WIN][WIN];
  int   col_in, row_in, col_out, row_out, frame_reqs;

  int          mismatches = 0;
  int          results_seen = 0;
  int          frames_done = 0;
  int          queued = 0;
  int unsigned cycles = 0;
  logic        calm;

  assign calm = (cycles >= 300) && (cycles < 800);

  always @(posedge clk) cycles <= cycles + 1;

  function automatic int eff_w();
    int cap;
    cap = (TB_MAX_W < WIDTH_CAP) ? TB_MAX_W : WIDTH_CAP;
    if (w_reg < 3) return 3;
    if (w_reg > cap) return cap;
    return int'(w_reg);
  endfunction

  function automatic int eff_h();
    return (h_reg < 3) ? 3 : int'(h_reg);
  endfunction

  function automatic void filter_step(input logic kind, input pix_t pin,
                                      output bit emit, output filt_t res);
    int   w, h, c, oc, orow, r, k, s, m;
    int   p [WIN][WIN];
    pix_t fresh;
    bit   border;
    w = eff_w();
    h = eff_h();
    emit = 1'b0;
    res = '0;
    if (col_in >= w) col_in = 0;
    c = col_in;
    fresh = (row_in < h && kind == 1'b0) ? pin : '0;

    for (r = 0; r < WIN; r++)
      for (k = 0; k < WIN - 1; k++) win[r][k] = win[r][k + 1];
    for (r = 0; r < STORED_ROWS; r++) win[r][WIN - 1] = line_mem[r][c];
    win[WIN - 1][WIN - 1] = fresh;
    for (r = 0; r + 1 < STORED_ROWS; r++) line_mem[r][c] = line_mem[r + 1][c];
    line_mem[STORED_ROWS - 1][c] = fresh;

    if (c + 1 >= w) begin
      col_in = 0;
      if (row_in < h) row_in++;
    end else begin
      col_in = c + 1;
    end

    if (frame_reqs >= 2 * w + 2) begin
      oc = (col_out >= w) ? 0 : col_out;
      orow = row_out;
      border = (orow == 0 || orow >= h - 1 || oc == 0 || oc >= w - 1);
      if (mode_reg == MODE_LOG && (orow == 1 || orow >= h - 2 || oc == 1 || oc >= w - 2)) begin
        border = 1'b1;
      end
      for (r = 0; r < WIN; r++)
        for (k = 0; k < WIN; k++) p[r][k] = int'(win[r][k]);

      if (border || mode_reg == MODE_COPY) begin
        res.value = win[2][2];
      end else begin
        if (mode_reg == MODE_LOG) begin
          s = 16 * p[2][2] - p[0][2] - p[4][2] - p[2][0] - p[2][4]
              - p[1][1] - p[1][3] - p[3][1] - p[3][3]
              - 2 * (p[1][2] + p[3][2] + p[2][1] + p[2][3]);
        end else begin
          m = (mode_reg == MODE_SOBEL) ? 2 : 1;
          s = -p[1][1] - m * p[2][1] - p[3][1] + p[1][3] + m * p[2][3] + p[3][3]
              - p[1][1] + p[3][1] - m * p[1][2] + m * p[3][2] - p[1][3] + p[3][3];
        end
        res.value = (s > 255) ? PIX_MAX : (s < 0) ? pix_t'(0) : pix_t'(s);
      end

      res.last = (orow >= h - 1 && oc >= w - 1);
      emit = 1'b1;
      if (res.last) begin
        col_in = 0;
        row_in = 0;
        col_out = 0;
        row_out = 0;
        frame_reqs = 0;
        return;
      end
      if (oc + 1 >= w) begin
        col_out = 0;
        if (row_out < int'(ROW_MAX)) row_out++;
      end else begin
        col_out = oc + 1;
      end
    end

    if (frame_reqs < int'(ITEMS_MAX)) frame_reqs++;
  endfunction

  always @(posedge clk) begin
    bit    emit;
    filt_t res;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        filter_step(s_axis_tuser, s_axis_tdata, emit, res);
        if (emit) filtered_q.push_back(res);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (raster_q.size() > 0 && !(raster_q[0].hold && filtered_q.size() > 0) &&
            (calm || $urandom_range(99) >= 20)) begin
          s_axis_tdata  <= raster_q[0].value;
          s_axis_tuser  <= raster_q[0].kind;
          s_axis_tvalid <= 1'b1;
          void'(raster_q.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (filtered_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 100) begin
            $display("%0t: result with none expected, pixel %0d last %0b",
                     $time, m_axis_tdata, m_axis_tlast);
          end
        end else begin
          want = filtered_q.pop_front();
          results_seen++;
          if (want.last) frames_done++;
          if (m_axis_tdata !== want.value) begin
            mismatches++;
            if (mismatches <= 100) begin
              $display("%0t: pixel_out expected %0d actual %0d",
                       $time, want.value, m_axis_tdata);
            end
          end
          if (m_axis_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= 100) begin
              $display("%0t: frame_last expected %0b actual %0b",
                       $time, want.last, m_axis_tlast);
            end
          end
        end
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 20);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    case (idx)
      CFG_WIDTH:  w_reg = val[WIDTH_W-1:0];
      CFG_HEIGHT: h_reg = val[HEIGHT_W-1:0];
      CFG_MODE:   mode_reg = val[MODE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_quiet();
    while (raster_q.size() > 0 || s_axis_tvalid || filtered_q.size() > 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Pixels first, then the drain; some pixels are replaced by flush ticks and
  // some flush ticks by late pixels.
  task automatic queue_items(input int total, input int pix_count, input bit pause_mid);
    int       k, early_pct, late_pct;
    pix_req_t r;
    case ($urandom_range(3))
      0:       early_pct = 0;
      1:       early_pct = 3;
      2:       early_pct = 8;
      default: early_pct = 30;
    endcase
    late_pct = $urandom_range(40);
    for (k = 0; k < total; k++) begin
      if (k < pix_count) r.kind = ($urandom_range(99) < early_pct);
      else r.kind = ($urandom_range(99) >= late_pct);
      case ($urandom_range(3))
        0:       r.value = '0;
        1:       r.value = PIX_MAX;
        default: r.value = pix_t'($urandom);
      endcase
      r.hold = pause_mid && (k == total / 2);
      raster_q.push_back(r);
    end
    queued += total;
  endtask

  task automatic run_phase(input int wv, input int hv, input int mode, input int frames);
    int f, fw, fh;
    write_reg(CFG_WIDTH, wv);
    write_reg(CFG_HEIGHT, hv);
    write_reg(CFG_MODE, mode);
    fw = eff_w();
    fh = eff_h();
    for (f = 0; f < frames; f++) begin
      queue_items(fh * fw + 2 * fw + 2, fh * fw, $urandom_range(3) == 0);
    end
    wait_quiet();
  endtask

  initial begin
    int       r, k, phase;
    pix_t     dir_pix [17];
    logic [16:0] dir_kind;
    pix_req_t req;

    for (r = 0; r < STORED_ROWS; r++)
      for (k = 0; k < TB_MAX_W; k++) line_mem[r][k] = '0;
    for (r = 0; r < WIN; r++)
      for (k = 0; k < WIN; k++) win[r][k] = '0;
    col_in = 0;
    row_in = 0;
    col_out = 0;
    row_out = 0;
    frame_reqs = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Smallest frame, with width and height written below their floor. Two
    // pixels are replaced by flush ticks and one drain tick carries a pixel.
    dir_pix  = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
                 8'hA5, 8'h5A, 8'd90, 8'hFF, 8'd0, 8'd1, 8'd128, 8'd254};
    dir_kind = 17'b11110_1111_0000_1000;
    write_reg(CFG_WIDTH, 0);
    write_reg(CFG_HEIGHT, 0);
    write_reg(CFG_MODE, MODE_PREWITT);
    for (k = 0; k < 17; k++) begin
      req.kind  = dir_kind[k];
      req.value = dir_pix[k];
      req.hold  = 1'b0;
      raster_q.push_back(req);
    end
    queued += 17;
    wait_quiet();

    // Tallest height, cut short in the middle of the frame.
    write_reg(CFG_WIDTH, 3);
    write_reg(CFG_HEIGHT, 65535);
    write_reg(CFG_MODE, MODE_SOBEL);
    queue_items(60, 60, 1'b1);
    wait_quiet();
    write_reg(CFG_HEIGHT, 10);
    while (frame_reqs != 0) begin
      queue_items(1, 0, 1'b0);
      wait_quiet();
    end

    phase = 0;
    while (queued < 550) begin
      case ($urandom_range(9))
        0:       r = $urandom_range(2);
        1:       r = $urandom_range(13, 40);
        default: r = $urandom_range(3, 12);
      endcase
      k = ($urandom_range(6) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
      run_phase(r, k, (phase < 4) ? phase : $urandom_range(3), $urandom_range(1, 2));
      phase++;
    end

    wait_quiet();
    $display("Sent %0d raster requests; checked %0d filtered pixels in %0d frames,",
             queued, results_seen, frames_done);
    $display("over all four modes, clamped sizes, early flushes and late pixels.");
    if (mismatches == 0 && filtered_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * 600000);
    $display("Timeout with %0d results still expected", filtered_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ grayscale_edge_filter_stream.f @@
hw/rtl/gefs_pkg.sv
hw/rtl/grayscale_edge_filter_stream.sv
tb/tb.sv
